// ===== hw/rtl/tpgz_pkg.sv =====
// tpgz_pkg: shared types and constants of the tagged packet gate with zero padding
// item structs for both channels, controller/datapath command and status structs
// no dependencies
package tpgz_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int MAX_FRAME    = 64;
	localparam int CNT_W        = 7;

	localparam logic [CNT_W-1:0] FRAME_MAX   = CNT_W'(MAX_FRAME);
	localparam logic [CNT_W-1:0] FRAME_RESET = CNT_W'(MAX_FRAME);
	localparam logic [CNT_W-1:0] CNT_ONE     = CNT_W'(1);

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] in_i;
		logic signed [SAMPLE_WIDTH-1:0] in_q;
		logic                           start_tag;
		logic                           end_tag;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] out_i;
		logic signed [SAMPLE_WIDTH-1:0] out_q;
		logic                           packet_start;
		logic                           is_padding;
		logic                           last_of_run;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic pad_step;
		logic tail_step;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic do_pad;
		logic pad_more;
		logic in_start;
		logic held_start;
		logic rem_one;
	} sts_t;

endpackage

// ===== hw/rtl/tagged_packet_gate_zero_pad_core.sv =====
// tagged_packet_gate_zero_pad_core: top level of the tagged packet gate with zero padding
// samples enter on the in channel, results leave on the out channel; frame length on cfg
// depends on tpgz_pkg, tpgz_ctrl, tpgz_dp
//
// usage:
//   in channel (in_valid/in_ready/in_data) takes one I/Q sample item with start and
//   end tags; out channel (out_valid/out_ready/out_data) gives result items.
//   cfg channel writes frame_length (clamped to 64); it is always ready and should be written
//   only while no item is in flight.
//   a passed sample appears in the output register in the cycle after it is accepted.
//   throughput is one item per cycle while samples pass or are dropped and out is not
//   stalled; an end tag inside a packet holds the input while the padding zeros after the
//   first go out, and for the held start item if it also starts a packet (tpgz_ctrl).
//   a new item is taken while the previous result is being taken by the receiver;
//   when the receiver stalls, the single output register holds and input stops.
//   reset clears the packet state, the counter and the output valid flag, and sets
//   frame_length to 64.
module tagged_packet_gate_zero_pad_core import tpgz_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tpgz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tpgz_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== hw/rtl/tpgz_ctrl.sv =====
// tpgz_ctrl: controller state machine of the packet gate
// sequences input accept, padding run and the deferred start sample
// depends on tpgz_pkg
module tpgz_ctrl import tpgz_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_PAD,
		ST_TAIL
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.pad_step  = 1'b0;
		cmd.tail_step = 1'b0;
		case (state_q)
			ST_ACCEPT: begin
				in_ready   = sts.slot_free;
				cmd.accept = in_valid && sts.slot_free;
			end
			ST_PAD: begin
				cmd.pad_step = sts.slot_free;
			end
			ST_TAIL: begin
				cmd.tail_step = sts.slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			case (state_q)
				ST_ACCEPT: begin
					if (cmd.accept && sts.do_pad) begin
						if (sts.pad_more) begin
							state_q <= ST_PAD;
						end else if (sts.in_start) begin
							state_q <= ST_TAIL;
						end
					end
				end
				ST_PAD: begin
					if (cmd.pad_step && sts.rem_one) begin
						state_q <= sts.held_start ? ST_TAIL : ST_ACCEPT;
					end
				end
				ST_TAIL: begin
					if (cmd.tail_step) begin
						state_q <= ST_ACCEPT;
					end
				end
				default: begin
					state_q <= ST_ACCEPT;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/tpgz_dp.sv =====
// tpgz_dp: datapath of the packet gate
// frame length register, packet state, sample counter, held item and output register
// depends on tpgz_pkg
module tpgz_dp import tpgz_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  in_item_t         in_data,
	input  logic             cfg_valid,
	input  logic [CNT_W-1:0] cfg_data,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	logic [CNT_W-1:0] frame_length_q;
	logic             in_packet_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] remaining_q;
	logic             st_q;
	logic signed [SAMPLE_WIDTH-1:0] i_q;
	logic signed [SAMPLE_WIDTH-1:0] q_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [CNT_W-1:0] flc;
	logic [CNT_W-1:0] pad_n;
	logic             pass;
	logic             emit;

	always_comb begin
		flc   = (frame_length_q > FRAME_MAX) ? FRAME_MAX : frame_length_q;
		pad_n = (flc > count_q) ? flc - count_q : '0;
		pass  = (in_packet_q && !in_data.end_tag) ||
			((!in_packet_q || in_data.end_tag) && in_data.start_tag);
		sts.slot_free  = !out_valid_q || out_ready;
		sts.do_pad     = in_packet_q && in_data.end_tag && (pad_n != '0);
		sts.pad_more   = pad_n > CNT_ONE;
		sts.in_start   = in_data.start_tag;
		sts.held_start = st_q;
		sts.rem_one    = remaining_q == CNT_ONE;
		emit = (cmd.accept && (sts.do_pad || pass)) || cmd.pad_step || cmd.tail_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= FRAME_RESET;
			in_packet_q    <= 1'b0;
			count_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				frame_length_q <= cfg_data;
			end
			if (cmd.accept) begin
				if (in_packet_q && in_data.end_tag) begin
					in_packet_q <= in_data.start_tag;
					count_q     <= in_data.start_tag ? CNT_ONE : '0;
				end else if (in_packet_q) begin
					if (count_q < FRAME_MAX) begin
						count_q <= count_q + CNT_ONE;
					end
				end else if (in_data.start_tag) begin
					in_packet_q <= 1'b1;
					count_q     <= CNT_ONE;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			i_q         <= in_data.in_i;
			q_q         <= in_data.in_q;
			st_q        <= in_data.start_tag;
			remaining_q <= pad_n - CNT_ONE;
			if (sts.do_pad) begin
				out_q.out_i        <= '0;
				out_q.out_q        <= '0;
				out_q.packet_start <= 1'b0;
				out_q.is_padding   <= 1'b1;
				out_q.last_of_run  <= (pad_n == CNT_ONE) && !in_data.start_tag;
			end else if (pass) begin
				out_q.out_i        <= in_data.in_i;
				out_q.out_q        <= in_data.in_q;
				out_q.packet_start <= !(in_packet_q && !in_data.end_tag);
				out_q.is_padding   <= 1'b0;
				out_q.last_of_run  <= 1'b1;
			end
		end else if (cmd.pad_step) begin
			remaining_q        <= remaining_q - CNT_ONE;
			out_q.out_i        <= '0;
			out_q.out_q        <= '0;
			out_q.packet_start <= 1'b0;
			out_q.is_padding   <= 1'b1;
			out_q.last_of_run  <= sts.rem_one && !st_q;
		end else if (cmd.tail_step) begin
			out_q.out_i        <= i_q;
			out_q.out_q        <= q_q;
			out_q.packet_start <= 1'b1;
			out_q.is_padding   <= 1'b0;
			out_q.last_of_run  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
